// ===== rtl/rlpr_pkg.sv =====
package rlpr_pkg;

  // fixed field widths
  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;
  localparam int BYTE_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int ERR_W   = 3;
  localparam int POS_W   = 2;

  // largest length the 13-bit count fields can carry
  localparam int COUNT_CAP = 8191;

  // default storage depth and register reset
  localparam int MAX_BYTES_DEFAULT = 4096;
  localparam logic [COUNT_W-1:0] MAX_REQ_RESET = 13'd4096;

  // request functions
  localparam logic [FUNC_W-1:0] FUNC_DATA    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ABORT   = 2'd3;

  // transport error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BUSY      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_FRAME = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_LARGE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd4;

  // position inside the current chunk
  localparam logic [POS_W-1:0] POS_IDLE    = 2'd0;
  localparam logic [POS_W-1:0] POS_HEADER  = 2'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 2'd2;
  localparam logic [POS_W-1:0] POS_DROP    = 2'd3;

  // one response item
  typedef struct packed {
    logic               reject_chunk;
    logic [ERR_W-1:0]   transport_error;
    logic               request_ready;
    logic [COUNT_W-1:0] received_count;
    logic [COUNT_W-1:0] expected_count;
    logic [BYTE_W-1:0]  read_byte;
  } rsp_item_t;

endpackage

// ===== rtl/rlpr_req_if.sv =====
interface rlpr_req_if
  import rlpr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [BYTE_W-1:0]  data_byte;
  logic               chunk_first;
  logic               chunk_last;
  logic               link_busy;
  logic [INDEX_W-1:0] read_index;

  modport source (
    output valid, func, data_byte, chunk_first, chunk_last, link_busy, read_index,
    input  ready
  );

  modport sink (
    input  valid, func, data_byte, chunk_first, chunk_last, link_busy, read_index,
    output ready
  );
endinterface

// ===== rtl/rlpr_rsp_if.sv =====
interface rlpr_rsp_if
  import rlpr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               reject_chunk;
  logic [ERR_W-1:0]   transport_error;
  logic               request_ready;
  logic [COUNT_W-1:0] received_count;
  logic [COUNT_W-1:0] expected_count;
  logic [BYTE_W-1:0]  read_byte;

  modport source (
    output valid, reject_chunk, transport_error, request_ready, received_count,
           expected_count, read_byte,
    input  ready
  );

  modport sink (
    input  valid, reject_chunk, transport_error, request_ready, received_count,
           expected_count, read_byte,
    output ready
  );
endinterface

// ===== rtl/rlpr_out_queue.sv =====
module rlpr_out_queue
  import rlpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rsp_item_t  push_item,
  output logic [1:0] level,
  output logic       pop,
  rlpr_rsp_if.source rsp
);

  logic [1:0] count;
  rsp_item_t  head;
  rsp_item_t  tail;

  assign level = count;
  assign pop   = (count != 2'd0) && rsp.ready;

  // two-entry queue, head drives the port
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b11: begin
          if (count == 2'd1) begin
            head <= push_item;
          end else begin
            head <= tail;
            tail <= push_item;
          end
        end
        2'b01: begin
          head  <= tail;
          count <= count - 2'd1;
        end
        2'b10: begin
          if (count == 2'd0) begin
            head <= push_item;
          end else begin
            tail <= push_item;
          end
          count <= count + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid           = (count != 2'd0);
  assign rsp.reject_chunk    = head.reject_chunk;
  assign rsp.transport_error = head.transport_error;
  assign rsp.request_ready   = head.request_ready;
  assign rsp.received_count  = head.received_count;
  assign rsp.expected_count  = head.expected_count;
  assign rsp.read_byte       = head.read_byte;

endmodule

// ===== rtl/reassemble_length_prefixed_request.sv =====
// Channel | Dir | Transfer                     | Payload
// req     | in  | req.valid && req.ready       | func, data_byte, chunk flags, link_busy,
//         |     |                              | read_index
// rsp     | out | rsp.valid && rsp.ready       | status, counts, read_byte
// cfg     | in  | cfg_write                    | max_request_length
//
// One request transfer per cycle while req.ready is high. A response passes the
// registered read of the request store in the read stage, then the two-entry
// output queue. Control state updates at the request transfer itself.
// Synchronous reset clears control state; the request store has no reset.
// req.ready drops only while the output queue and the read stage hold two
// responses that rsp has not taken.
module reassemble_length_prefixed_request
  import rlpr_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data,
  rlpr_req_if.sink           req,
  rlpr_rsp_if.source         rsp
);

  localparam int ADDR_W  = $clog2(MAX_BYTES);
  localparam int LIM_CAP = (MAX_BYTES < COUNT_CAP) ? MAX_BYTES : COUNT_CAP;

  // configuration
  logic [COUNT_W-1:0] max_request_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_request_length <= MAX_REQ_RESET;
    end else if (cfg_write) begin
      max_request_length <= cfg_data;
    end
  end

  // control state
  logic               assembling, assembling_next;
  logic               ready_flag, ready_flag_next;
  logic [COUNT_W-1:0] announced_length, announced_length_next;
  logic [COUNT_W-1:0] stored_count, stored_count_next;
  logic [BYTE_W-1:0]  header_low_byte, header_low_byte_next;
  logic [POS_W-1:0]   position_in_chunk, position_in_chunk_next;
  logic [ERR_W-1:0]   chunk_error_code, chunk_error_code_next;

  // per-transfer outputs of the update logic
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               emit;
  rsp_item_t          emit_item;
  logic               rd_sel;

  logic               accept;
  logic [1:0]         q_level;
  logic               q_pop;
  logic               s1_valid;

  // response stage and queue pacing
  assign accept    = req.valid && req.ready;
  assign req.ready = ({1'b0, q_level} + {2'b00, s1_valid} - {2'b00, q_pop}) <= 3'd1;

  // effective header length limit
  logic [COUNT_W-1:0] length_limit;
  assign length_limit = (32'(max_request_length) > LIM_CAP) ? COUNT_W'(LIM_CAP)
                                                            : max_request_length;

  // next state for one request
  always_comb begin
    logic [15:0] hdr_len;
    logic        store;
    logic [ERR_W-1:0] err;

    assembling_next        = assembling;
    ready_flag_next        = ready_flag;
    announced_length_next  = announced_length;
    stored_count_next      = stored_count;
    header_low_byte_next   = header_low_byte;
    position_in_chunk_next = position_in_chunk;
    chunk_error_code_next  = chunk_error_code;
    wr_en                  = 1'b0;
    wr_addr                = ADDR_W'(stored_count);
    emit                   = 1'b0;
    rd_sel                 = 1'b0;
    emit_item              = '0;
    hdr_len                = {req.data_byte, header_low_byte};
    store                  = 1'b0;
    err                    = ERR_NONE;

    case (req.func)
      FUNC_READ: begin
        emit   = 1'b1;
        rd_sel = 32'(req.read_index) < MAX_BYTES;
        emit_item.transport_error = ERR_NONE;
        emit_item.request_ready   = ready_flag;
        emit_item.received_count  = stored_count;
        emit_item.expected_count  = announced_length;
      end
      FUNC_RELEASE: begin
        if (ready_flag) begin
          ready_flag_next       = 1'b0;
          assembling_next       = 1'b0;
          announced_length_next = '0;
          stored_count_next     = '0;
        end
      end
      FUNC_ABORT: begin
        ready_flag_next        = 1'b0;
        assembling_next        = 1'b0;
        announced_length_next  = '0;
        stored_count_next      = '0;
        position_in_chunk_next = POS_IDLE;
        chunk_error_code_next  = ERR_NONE;
      end
      default: begin
        // chunk opening, header and payload
        if (req.chunk_first || position_in_chunk == POS_IDLE) begin
          chunk_error_code_next = ERR_NONE;
          if (req.link_busy || ready_flag) begin
            chunk_error_code_next  = ERR_BUSY;
            position_in_chunk_next = POS_DROP;
          end else if (!assembling) begin
            header_low_byte_next   = req.data_byte;
            position_in_chunk_next = POS_HEADER;
          end else begin
            position_in_chunk_next = POS_PAYLOAD;
            store                  = 1'b1;
          end
        end else if (position_in_chunk == POS_HEADER) begin
          if (hdr_len == 16'd0 || hdr_len > {3'b000, length_limit}) begin
            chunk_error_code_next  = ERR_TOO_LARGE;
            position_in_chunk_next = POS_DROP;
          end else begin
            assembling_next        = 1'b1;
            announced_length_next  = COUNT_W'(hdr_len);
            stored_count_next      = '0;
            position_in_chunk_next = POS_PAYLOAD;
          end
        end else if (position_in_chunk == POS_PAYLOAD) begin
          store = 1'b1;
        end

        // payload write or overflow
        if (store) begin
          if (stored_count >= announced_length || 32'(stored_count) >= MAX_BYTES) begin
            assembling_next        = 1'b0;
            announced_length_next  = '0;
            stored_count_next      = '0;
            chunk_error_code_next  = ERR_OVERFLOW;
            position_in_chunk_next = POS_DROP;
          end else begin
            wr_en             = 1'b1;
            stored_count_next = stored_count + COUNT_W'(1);
          end
        end

        // chunk end status
        if (req.chunk_last) begin
          err = chunk_error_code_next;
          if (position_in_chunk_next == POS_HEADER && err == ERR_NONE) begin
            err = ERR_BAD_FRAME;
          end
          if (err == ERR_NONE && assembling_next &&
              stored_count_next == announced_length_next) begin
            ready_flag_next = 1'b1;
            assembling_next = 1'b0;
          end
          emit = 1'b1;
          emit_item.reject_chunk    = (err == ERR_BAD_FRAME) || (err == ERR_TOO_LARGE) ||
                                      (err == ERR_OVERFLOW);
          emit_item.transport_error = err;
          emit_item.request_ready   = ready_flag_next;
          emit_item.received_count  = stored_count_next;
          emit_item.expected_count  = announced_length_next;
          position_in_chunk_next    = POS_IDLE;
          chunk_error_code_next     = ERR_NONE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      assembling        <= 1'b0;
      ready_flag        <= 1'b0;
      announced_length  <= '0;
      stored_count      <= '0;
      header_low_byte   <= '0;
      position_in_chunk <= POS_IDLE;
      chunk_error_code  <= ERR_NONE;
    end else if (accept) begin
      assembling        <= assembling_next;
      ready_flag        <= ready_flag_next;
      announced_length  <= announced_length_next;
      stored_count      <= stored_count_next;
      header_low_byte   <= header_low_byte_next;
      position_in_chunk <= position_in_chunk_next;
      chunk_error_code  <= chunk_error_code_next;
    end
  end

  // request store, registered read
  logic [BYTE_W-1:0] request_store [MAX_BYTES];
  logic [BYTE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      request_store[wr_addr] <= req.data_byte;
    end
    if (accept && req.func == FUNC_READ) begin
      rd_data <= request_store[ADDR_W'(req.read_index)];
    end
  end

  // read stage: registers the response alongside the store read
  rsp_item_t s1_item;
  logic      s1_rd_sel;
  rsp_item_t push_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item   <= emit_item;
      s1_rd_sel <= rd_sel;
    end
  end

  always_comb begin
    push_item           = s1_item;
    push_item.read_byte = s1_rd_sel ? rd_data : '0;
  end

  rlpr_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_item (push_item),
    .level     (q_level),
    .pop       (q_pop),
    .rsp       (rsp)
  );

  // checks
  a_ready_not_assembling: assert property (@(posedge clk) disable iff (rst)
    !(assembling && ready_flag))
    else $error("request ready while still assembling");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= announced_length)
    else $error("stored count beyond announced length");

  a_stage_from_transfer: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(accept))
    else $error("response stage loaded without a request transfer");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && q_level == 2'd2) |-> q_pop)
    else $error("response pushed into a full queue");

endmodule
